// ----- src/dsfr_pkg.sv -----
// Types, constants and the CRC-8 byte update for the DLE/STX frame receiver.
// No dependencies; the receiver and the checker import this package.
package dsfr_pkg;

	localparam logic [7:0] START_BYTE = 8'd144;
	localparam logic [7:0] FRAME_BYTE = 8'd2;
	localparam logic [7:0] CRC_POLY   = 8'h07;

	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_END     = 1'b1;

	typedef enum logic [4:0] {
		PH_HUNT        = 5'b00001,
		PH_AFTER_START = 5'b00010,
		PH_LENGTH      = 5'b00100,
		PH_PAYLOAD     = 5'b01000,
		PH_CHECK       = 5'b10000
	} phase_t;

	typedef struct packed {
		logic [7:0] rx_byte;
	} rx_item_t;

	typedef struct packed {
		logic       result_kind;
		logic [7:0] payload_byte;
		logic [7:0] byte_index;
		logic [7:0] frame_length;
		logic       check_ok;
		logic [7:0] received_check;
		logic [7:0] computed_check;
	} result_t;

	// MSB-first CRC-8, one byte per call
	function automatic logic [7:0] crc8_step(input logic [7:0] acc, input logic [7:0] b);
		logic [7:0] v;
		v = acc ^ b;
		for (int k = 0; k < 8; k++) begin
			if (v[7]) begin
				v = {v[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				v = {v[6:0], 1'b0};
			end
		end
		return v;
	endfunction

endpackage

// ----- src/dsfr_stream_if.sv -----
// Valid/ready stream channel used for the receive and result sides.
// Payload type is a parameter.
interface dsfr_stream_if #(
	parameter type payload_t = logic [7:0]
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- src/dle_stx_frame_receiver_crc8.sv -----
// DLE/STX length-framed byte receiver with CRC-8 (poly 0x07) payload check.
// Depends on dsfr_pkg and dsfr_stream_if.

// Takes one received byte per cycle on rx and hunts for 144 followed by 2,
// then a length byte, that many payload bytes and one check byte. Each payload
// byte comes out on res with its index; the check byte gives a frame-end
// result with the received and computed CRC-8. Throughput is one byte per
// clock when not stalled: the phase step and the byte-wide CRC update finish
// in the cycle a byte is taken, and the result sits in an output register.
// rx.ready drops only while a held result has not been taken; each result
// appears in the cycle after its transfer. Start bytes in a frame are plain data.
module dle_stx_frame_receiver_crc8
	import dsfr_pkg::*;
(
	input logic          clk,
	input logic          arst_n,
	dsfr_stream_if.sink   rx,
	dsfr_stream_if.source res
);

	phase_t     phase_q, phase_d;
	logic [7:0] remaining_q, remaining_d;
	logic [7:0] position_q, position_d;
	logic [7:0] length_q, length_d;
	logic [7:0] crc_q, crc_d;

	logic       res_valid_q;
	result_t    res_q, res_d;
	logic       emit;
	logic       accept;
	logic [7:0] b;
	logic [7:0] crc_next;

	assign rx.ready  = !res_valid_q || res.ready;
	assign accept    = rx.valid && rx.ready;
	assign b         = rx.data.rx_byte;
	assign crc_next  = crc8_step(crc_q, b);
	assign res.valid = res_valid_q;
	assign res.data  = res_q;

	always_comb begin
		phase_d     = phase_q;
		remaining_d = remaining_q;
		position_d  = position_q;
		length_d    = length_q;
		crc_d       = crc_q;
		emit        = 1'b0;
		res_d       = '0;
		case (phase_q)
			PH_AFTER_START: begin
				phase_d = (b == FRAME_BYTE) ? PH_LENGTH : PH_HUNT;
			end
			PH_LENGTH: begin
				length_d    = b;
				remaining_d = b;
				position_d  = '0;
				crc_d       = '0;
				phase_d     = (b == 8'd0) ? PH_CHECK : PH_PAYLOAD;
			end
			PH_PAYLOAD: begin
				emit               = 1'b1;
				res_d.result_kind  = KIND_PAYLOAD;
				res_d.payload_byte = b;
				res_d.byte_index   = position_q;
				res_d.frame_length = length_q;
				crc_d              = crc_next;
				position_d         = position_q + 8'd1;
				remaining_d        = remaining_q - 8'd1;
				// last payload byte: the next byte is the check byte
				if (remaining_q == 8'd1) begin
					phase_d = PH_CHECK;
				end
			end
			PH_CHECK: begin
				emit                 = 1'b1;
				res_d.result_kind    = KIND_END;
				res_d.frame_length   = length_q;
				res_d.check_ok       = (b == crc_q);
				res_d.received_check = b;
				res_d.computed_check = crc_q;
				phase_d              = PH_HUNT;
			end
			default: begin
				phase_d = (b == START_BYTE) ? PH_AFTER_START : PH_HUNT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HUNT;
			remaining_q <= '0;
			position_q  <= '0;
			length_q    <= '0;
			crc_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				phase_q     <= phase_d;
				remaining_q <= remaining_d;
				position_q  <= position_d;
				length_q    <= length_d;
				crc_q       <= crc_d;
			end
			if (rx.ready) begin
				res_valid_q <= accept && emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit) begin
			res_q <= res_d;
		end
	end

endmodule

// ----- src/dsfr_checker.sv -----
// Port-level assertions for dle_stx_frame_receiver_crc8, bound to the top level.
// Depends on dsfr_pkg and the top-level module.
module dsfr_checker
	import dsfr_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    rx_ready,
	input logic    res_valid,
	input logic    res_ready,
	input result_t res_data
);

	// a result not taken holds its value
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_data))
		else $error("result changed while stalled");

	// input side stalls exactly when a held result is not taken
	a_rx_stall: assert property (@(posedge clk) disable iff (!arst_n)
		rx_ready == (!res_valid || res_ready))
		else $error("rx ready does not follow result stall");

	a_end_check: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.result_kind == KIND_END |->
		res_data.check_ok == (res_data.received_check == res_data.computed_check))
		else $error("check_ok disagrees with check bytes");

	a_payload_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.result_kind == KIND_PAYLOAD |->
		!res_data.check_ok && res_data.received_check == 8'd0 &&
		res_data.computed_check == 8'd0)
		else $error("payload transfer carries check fields");

endmodule

bind dle_stx_frame_receiver_crc8 dsfr_checker u_dsfr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rx_ready  (rx.ready),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.res_data  (res.data)
);
